// ----- rtl/xoro_pkg.sv -----
`default_nettype none

package xoro_pkg;

  localparam int SEED_W = 64;
  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 23;
  localparam int EXP_W  = 8;
  localparam int ADDR_W = 4;
  localparam int IN_W   = 2 * VAL_W;
  localparam int OUT_W  = WORD_W + VAL_W + VAL_W;

  localparam int DIV_STEPS = WORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] SM_MUL1  = 64'hBF58476D1CE4E5B9;
  localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94D049BB133111EB;

  localparam int ROT_A = 55;
  localparam int SHL_A = 14;
  localparam int ROT_B = 36;
  localparam int XS_1  = 30;
  localparam int XS_2  = 27;
  localparam int XS_3  = 31;

  // exponent of a fraction whose leading one sits at bit FRAC_W-1
  localparam logic [EXP_W-1:0] EXP_TOP = 8'd126;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CTR_INIT,
    OP_CTR_STEP,
    OP_XS1,
    OP_XS2,
    OP_XS3,
    OP_MUL_LL,
    OP_MUL_LH,
    OP_MUL_HL,
    OP_SET_A,
    OP_SET_B,
    OP_START,
    OP_DIV_STEP,
    OP_LOAD_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic mul2;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/xoro_ctrl.sv -----
`default_nettype none

module xoro_ctrl
  import xoro_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  seed_we_i,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] ST_SEED = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [3:0] STEP_CTR = 4'd0;
  localparam logic [3:0] STEP_X1  = 4'd1;
  localparam logic [3:0] STEP_M1L = 4'd2;
  localparam logic [3:0] STEP_M1C = 4'd3;
  localparam logic [3:0] STEP_M1H = 4'd4;
  localparam logic [3:0] STEP_X2  = 4'd5;
  localparam logic [3:0] STEP_M2L = 4'd6;
  localparam logic [3:0] STEP_M2C = 4'd7;
  localparam logic [3:0] STEP_M2H = 4'd8;
  localparam logic [3:0] STEP_X3  = 4'd9;
  localparam logic [3:0] STEP_SET = 4'd10;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             word_q, word_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    word_d      = word_q;
    cmd_o.op    = OP_NONE;
    cmd_o.mul2  = 1'b0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_SEED: begin
        case (cnt_q[3:0])
          STEP_CTR: cmd_o.op = word_q ? OP_CTR_STEP : OP_CTR_INIT;
          STEP_X1:  cmd_o.op = OP_XS1;
          STEP_M1L: cmd_o.op = OP_MUL_LL;
          STEP_M1C: cmd_o.op = OP_MUL_LH;
          STEP_M1H: cmd_o.op = OP_MUL_HL;
          STEP_X2:  cmd_o.op = OP_XS2;
          STEP_M2L: begin
            cmd_o.op   = OP_MUL_LL;
            cmd_o.mul2 = 1'b1;
          end
          STEP_M2C: begin
            cmd_o.op   = OP_MUL_LH;
            cmd_o.mul2 = 1'b1;
          end
          STEP_M2H: begin
            cmd_o.op   = OP_MUL_HL;
            cmd_o.mul2 = 1'b1;
          end
          STEP_X3:  cmd_o.op = OP_XS3;
          STEP_SET: cmd_o.op = word_q ? OP_SET_B : OP_SET_A;
          default:  cmd_o.op = OP_NONE;
        endcase
        if (cnt_q[3:0] == STEP_SET) begin
          cnt_d  = '0;
          word_d = 1'b1;
          if (word_q) begin
            state_d = ST_IDLE;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready_o = !seed_we_i;
        if (in_valid_i && !seed_we_i) begin
          cmd_o.op = OP_START;
          cnt_d    = '0;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_LOAD_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_SEED;
    endcase
    if (seed_we_i) begin
      state_d = ST_SEED;
      cnt_d   = '0;
      word_d  = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_LOAD_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEED;
      cnt_q       <= '0;
      word_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/xoro_datapath.sv -----
`default_nettype none

module xoro_datapath
  import xoro_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  cmd_t             cmd_i,
  input  wire              seed_we_i,
  input  wire [SEED_W-1:0] seed_i,
  output logic [SEED_W-1:0] seed_o,
  input  wire [IN_W-1:0]   in_data_i,
  output logic [OUT_W-1:0] out_data_o,
  output logic             out_err_o
);

  logic [SEED_W-1:0] seed_q;
  logic [WORD_W-1:0] ctr_q, z_q, acc_q;
  logic [WORD_W-1:0] sa_q, sb_q;

  logic [WORD_W-1:0] div_q;
  logic [VAL_W-1:0]  rem_q;
  logic [VAL_W:0]    span_q;
  logic [VAL_W-1:0]  lo_q;
  logic              err_q;
  logic [WORD_W-1:0] raw_q;
  logic [FRAC_W-1:0] frac_q;
  logic [EXP_W-1:0]  exp_q;

  logic [OUT_W-1:0]  out_q;
  logic              out_err_q;

  // seeding multiplier, one 32x32 partial product per cycle
  logic [WORD_W-1:0] mconst;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [WORD_W-1:0] prod;

  assign mconst = cmd_i.mul2 ? SM_MUL2 : SM_MUL1;
  assign mul_a  = (cmd_i.op == OP_MUL_HL) ? z_q[WORD_W-1:HALF_W] : z_q[HALF_W-1:0];
  assign mul_b  = (cmd_i.op == OP_MUL_LH) ? mconst[WORD_W-1:HALF_W] : mconst[HALF_W-1:0];
  assign prod   = mul_a * mul_b;

  // generator step
  logic [WORD_W-1:0] s_x, next_a, next_b, raw_x;
  assign raw_x  = sa_q + sb_q;
  assign s_x    = sa_q ^ sb_q;
  assign next_a = {sa_q[WORD_W-ROT_A-1:0], sa_q[WORD_W-1:WORD_W-ROT_A]}
                  ^ s_x ^ (s_x << SHL_A);
  assign next_b = {s_x[WORD_W-ROT_B-1:0], s_x[WORD_W-1:WORD_W-ROT_B]};

  logic signed [VAL_W:0] lo_x, hi_x, span_x;
  assign lo_x   = {in_data_i[VAL_W-1], in_data_i[VAL_W-1:0]};
  assign hi_x   = {in_data_i[IN_W-1], in_data_i[IN_W-1:VAL_W]};
  assign span_x = hi_x - lo_x + $signed({{VAL_W{1'b0}}, 1'b1});

  // restoring remainder step
  logic [VAL_W:0]   rem_sh;
  logic [VAL_W+1:0] trial;
  assign rem_sh = {rem_q, div_q[WORD_W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, span_q};

  logic [VAL_W-1:0]  ranged;
  logic [VAL_W-1:0]  fbits;
  assign ranged = err_q ? lo_q : lo_q + rem_q;
  assign fbits  = (frac_q == '0) ? '0 : {1'b0, exp_q, frac_q[FRAC_W-2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_we_i) begin
      seed_q <= seed_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CTR_INIT: ctr_q <= seed_q + SM_GAMMA;
      OP_CTR_STEP: ctr_q <= ctr_q + SM_GAMMA;
      OP_XS1:      z_q   <= ctr_q ^ (ctr_q >> XS_1);
      OP_XS2:      z_q   <= z_q ^ (z_q >> XS_2);
      OP_XS3:      z_q   <= z_q ^ (z_q >> XS_3);
      OP_MUL_LL:   acc_q <= prod;
      OP_MUL_LH:   acc_q <= {acc_q[WORD_W-1:HALF_W] + prod[HALF_W-1:0], acc_q[HALF_W-1:0]};
      OP_MUL_HL:   z_q   <= {acc_q[WORD_W-1:HALF_W] + prod[HALF_W-1:0], acc_q[HALF_W-1:0]};
      OP_SET_A:    sa_q  <= z_q;
      OP_SET_B:    sb_q  <= z_q;
      OP_START: begin
        raw_q  <= raw_x;
        div_q  <= raw_x;
        sa_q   <= next_a;
        sb_q   <= next_b;
        rem_q  <= '0;
        span_q <= span_x[VAL_W:0];
        lo_q   <= in_data_i[VAL_W-1:0];
        err_q  <= hi_x < lo_x;
        frac_q <= raw_x[WORD_W-1 -: FRAC_W];
        exp_q  <= EXP_TOP;
      end
      OP_DIV_STEP: begin
        div_q <= div_q << 1;
        rem_q <= trial[VAL_W+1] ? rem_sh[VAL_W-1:0] : trial[VAL_W-1:0];
        if (frac_q != '0 && !frac_q[FRAC_W-1]) begin
          frac_q <= frac_q << 1;
          exp_q  <= exp_q - 1'b1;
        end
      end
      OP_LOAD_OUT: begin
        out_q     <= {fbits, ranged, raw_q};
        out_err_q <= err_q;
      end
      default: ;
    endcase
  end

  assign seed_o     = seed_q;
  assign out_data_o = out_q;
  assign out_err_o  = out_err_q;

endmodule

`default_nettype wire

// ----- rtl/xoroshiro128plus_generator.sv -----
// xoroshiro128+ random generator with splitmix64 seeding.
// Input stream: one request per item; tdata carries the inclusive bounds of
// the ranged result. Output stream: one result per request; tdata carries
// the raw 64-bit sum, the ranged integer and the single-precision fraction,
// tuser flags an inverted range (the ranged field then equals the low bound).
// APB port: one 64-bit register, the seed, at each address with bit 3 clear;
// writing it re-derives the 128-bit state through the shared 32x32 multiplier;
// s_axis_tready_o is low meanwhile. The same seeding runs after reset (seed
// zero) before the first request is taken.
// The remainder runs one quotient bit a cycle through a 33-bit subtractor.
// One item is in flight at a time. A waiting result sits in the output
// register; the next request is still taken, and its result waits until the
// receiver takes the earlier one.
`default_nettype none

module xoroshiro128plus_generator
  import xoro_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire [IN_W-1:0]    s_axis_tdata_i,   // range_low, range_high
  output logic              m_axis_tvalid_o,
  input  wire               m_axis_tready_i,
  output logic [OUT_W-1:0]  m_axis_tdata_o,   // raw_value, ranged_value, unit_float_bits
  output logic              m_axis_tuser_o,   // range_error
  input  wire               psel_i,
  input  wire               penable_i,
  input  wire               pwrite_i,
  input  wire [ADDR_W-1:0]  paddr_i,
  input  wire [SEED_W-1:0]  pwdata_i,
  output logic [SEED_W-1:0] prdata_o,
  output logic              pready_o
);

  cmd_t        cmd;
  logic        seed_we;
  logic [SEED_W-1:0] seed;

  assign pready_o = 1'b1;
  assign seed_we  = psel_i && penable_i && pwrite_i && !paddr_i[ADDR_W-1];
  assign prdata_o = paddr_i[ADDR_W-1] ? '0 : seed;

  xoro_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (seed_we),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  xoro_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .seed_we_i  (seed_we),
    .seed_i     (pwdata_i),
    .seed_o     (seed),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o),
    .out_err_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ----- rtl/xoro_checker.sv -----
`default_nettype none

module xoro_checker
  import xoro_pkg::*;
(
  input wire              clk_i,
  input wire              rst_ni,
  input wire              s_axis_tvalid_i,
  input wire              s_axis_tready_o,
  input wire              m_axis_tvalid_o,
  input wire              m_axis_tready_i,
  input wire [OUT_W-1:0]  m_axis_tdata_o,
  input wire              m_axis_tuser_o,
  input wire              psel_i,
  input wire              penable_i,
  input wire              pwrite_i,
  input wire [ADDR_W-1:0] paddr_i,
  input wire              pready_o
);

  // one request in flight: ready drops after a request is taken
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while another in flight");

  // a seed write starts reseeding, so no request is taken next
  a_reseed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && pready_o && !paddr_i[ADDR_W-1]
    |=> !s_axis_tready_o)
    else $error("request taken during reseeding");

  // a new result never rises straight after the input side was open
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result without a finished computation");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o)
    && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

endmodule

bind xoroshiro128plus_generator xoro_checker u_chk (.*);

`default_nettype wire
